FILE: design/masked_weighted_grid_smoother_top_macros.svh
// Assertion macros shared by the grid smoother modules.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef MASKED_WEIGHTED_GRID_SMOOTHER_TOP_MACROS_SVH
`define MASKED_WEIGHTED_GRID_SMOOTHER_TOP_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define MWGS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define MWGS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mwgs_pkg.sv
// Shared constants and types of the masked weighted grid smoother.
// No dependencies.
`timescale 1ns / 1ps
package mwgs_pkg;
    localparam int VALUE_BITS      = 32;
    localparam int MAX_GRID_WIDTH  = 256;
    localparam int MAX_GRID_HEIGHT = 256;
    localparam int COL_BITS        = $clog2(MAX_GRID_WIDTH);
    localparam int ROW_BITS        = $clog2(MAX_GRID_HEIGHT + 1);
    localparam int DIM_BITS        = 9;
    localparam int IDX_OUT_BITS    = 8;
    localparam int NUM_LANES       = 4;
    localparam int NUM_TAPS        = 9;
    localparam int CENTER_TAP      = 4;
    localparam int SUM_BITS        = VALUE_BITS + 4;
    localparam int WS_BITS         = 5;
    localparam int QDEPTH          = 4;
    localparam int QPTR_BITS       = $clog2(QDEPTH);
    localparam int CFG_IDX_BITS    = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [2:0] W_NONE   = 3'd0;
    localparam logic [2:0] W_CORNER = 3'd1;
    localparam logic [2:0] W_EDGE   = 3'd2;
    localparam logic [2:0] W_CENTER = 3'd4;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        t_value [NUM_LANES-1:0] vals;
        logic                   ok;
    } t_cell;

    typedef struct packed {
        t_value [NUM_LANES-1:0] vals;
        logic [2:0]             wt;
    } t_tap;

    typedef struct packed {
        t_tap [NUM_TAPS-1:0]     taps;
        logic [IDX_OUT_BITS-1:0] row;
        logic [IDX_OUT_BITS-1:0] col;
        logic                    last;
        logic                    done;
    } t_job;

    function automatic logic [2:0] kernel_weight(input int i, input int jj);
        logic [2:0] w;
        if (i == 1 && jj == 1) begin
            w = W_CENTER;
        end else if (i == 1 || jj == 1) begin
            w = W_EDGE;
        end else begin
            w = W_CORNER;
        end
        return w;
    endfunction
endpackage

FILE: design/mwgs_front.sv
// Front part: takes cells, keeps the line buffers and the 3x3 window,
// and issues smoothing jobs with per-tap weights. Depends on mwgs_pkg.
`timescale 1ns / 1ps
module mwgs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [4*mwgs_pkg::VALUE_BITS-1:0]   i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mwgs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mwgs_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic                                i_q_space,
    output logic                                o_push,
    output mwgs_pkg::t_job                      o_job
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_LOAD = 2'd1;
    localparam logic [1:0] F_J1   = 2'd2;
    localparam logic [1:0] F_J2   = 2'd3;

    logic [1:0]                      r_state;
    logic [mwgs_pkg::COL_BITS-1:0]   r_w_m1;
    logic [mwgs_pkg::ROW_BITS-1:0]   r_h;
    logic [mwgs_pkg::COL_BITS-1:0]   r_col;
    logic [mwgs_pkg::ROW_BITS-1:0]   r_row;
    logic [mwgs_pkg::COL_BITS-1:0]   r_c;
    logic [mwgs_pkg::ROW_BITS-1:0]   r_r;
    logic                            r_last_col;
    logic                            r_up_ok;
    logic                            r_low_ok;
    mwgs_pkg::t_cell                 r_nc;
    mwgs_pkg::t_cell                 r_up_rd;
    mwgs_pkg::t_cell                 r_mid_rd;
    mwgs_pkg::t_cell [2:0][2:0]      r_win;
    mwgs_pkg::t_cell                 r_upper [mwgs_pkg::MAX_GRID_WIDTH];
    mwgs_pkg::t_cell                 r_middle [mwgs_pkg::MAX_GRID_WIDTH];

    logic                            accept;
    logic                            cfg_wr;
    logic [mwgs_pkg::DIM_BITS-1:0]   dim_max;
    logic [mwgs_pkg::ROW_BITS-1:0]   dim_clamped;
    mwgs_pkg::t_job                  job1;
    mwgs_pkg::t_job                  job2;

    function automatic mwgs_pkg::t_job make_job(
        input mwgs_pkg::t_cell [2:0][2:0]    win,
        input int                            k,
        input logic [mwgs_pkg::COL_BITS-1:0] c,
        input logic                          up_ok,
        input logic                          low_ok
    );
        mwgs_pkg::t_job job;
        int             j;
        logic           present;
        job = '0;
        for (int i = 0; i < 3; i++) begin
            for (int jj = 0; jj < 3; jj++) begin
                j = k - 1 + jj;
                present = 1'b0;
                if (j <= 2) begin
                    present = win[i][j].ok && (int'(c) + j >= 2)
                              && (i != 0 || up_ok) && (i != 2 || low_ok);
                    job.taps[i*3+jj].vals = win[i][j].vals;
                end
                job.taps[i*3+jj].wt = present ? mwgs_pkg::kernel_weight(i, jj)
                                              : mwgs_pkg::W_NONE;
            end
        end
        return job;
    endfunction

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == F_IDLE) && i_q_space;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign dim_max     = (i_cfg_index == mwgs_pkg::CFG_GRID_WIDTH)
                         ? mwgs_pkg::DIM_BITS'(mwgs_pkg::MAX_GRID_WIDTH)
                         : mwgs_pkg::DIM_BITS'(mwgs_pkg::MAX_GRID_HEIGHT);

    always_comb begin
        if (i_cfg_data == '0) begin
            dim_clamped = mwgs_pkg::ROW_BITS'(1);
        end else if (i_cfg_data > dim_max) begin
            dim_clamped = mwgs_pkg::ROW_BITS'(dim_max);
        end else begin
            dim_clamped = mwgs_pkg::ROW_BITS'(i_cfg_data);
        end
    end

    always_comb begin
        job1      = make_job(r_win, 1, r_c, r_up_ok, r_low_ok);
        job1.row  = mwgs_pkg::IDX_OUT_BITS'(r_r - 1'b1);
        job1.col  = mwgs_pkg::IDX_OUT_BITS'(r_c - 1'b1);
        job1.last = !r_last_col;
        job1.done = 1'b0;
        job2      = make_job(r_win, 2, r_c, r_up_ok, r_low_ok);
        job2.row  = mwgs_pkg::IDX_OUT_BITS'(r_r - 1'b1);
        job2.col  = mwgs_pkg::IDX_OUT_BITS'(r_c);
        job2.last = 1'b1;
        job2.done = (r_r == r_h);
    end

    assign o_job  = (r_state == F_J1) ? job1 : job2;
    assign o_push = ((r_state == F_J1) && (r_r != '0) && (r_c != '0))
                    || ((r_state == F_J2) && (r_r != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_w_m1  <= mwgs_pkg::COL_BITS'(mwgs_pkg::MAX_GRID_WIDTH - 1);
            r_h     <= mwgs_pkg::ROW_BITS'(mwgs_pkg::MAX_GRID_HEIGHT);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_LOAD;
                    end
                end
                F_LOAD: begin
                    r_state <= F_J1;
                end
                F_J1: begin
                    r_state <= r_last_col ? F_J2 : F_IDLE;
                end
                F_J2: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
            if (cfg_wr) begin
                r_col <= '0;
                r_row <= '0;
                if (i_cfg_index == mwgs_pkg::CFG_GRID_WIDTH) begin
                    r_w_m1 <= mwgs_pkg::COL_BITS'(dim_clamped - 1'b1);
                end else begin
                    r_h <= dim_clamped;
                end
            end else if (accept) begin
                if (r_col == r_w_m1) begin
                    r_col <= '0;
                    r_row <= (r_row >= r_h) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c          <= r_col;
            r_r          <= r_row;
            r_last_col   <= (r_col == r_w_m1);
            r_up_ok      <= (r_row >= mwgs_pkg::ROW_BITS'(2));
            r_low_ok     <= (r_row < r_h);
            r_nc.vals    <= i_s_tdata;
            r_nc.ok      <= i_s_tuser && (r_row < r_h);
            r_up_rd      <= r_upper[r_col];
            r_mid_rd     <= r_middle[r_col];
        end
        if (r_state == F_LOAD) begin
            r_upper[r_c]  <= r_mid_rd;
            r_middle[r_c] <= r_nc;
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_mid_rd;
            r_win[2][2] <= r_nc;
        end
    end
endmodule

FILE: design/mwgs_jobq.sv
// Short job queue between the front and the back part.
// Depends on mwgs_pkg.
`timescale 1ns / 1ps
module mwgs_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mwgs_pkg::t_job i_job,
    output logic           o_space,
    output logic           o_valid,
    output mwgs_pkg::t_job o_job,
    input  logic           i_pop
);
    mwgs_pkg::t_job                   r_mem [mwgs_pkg::QDEPTH];
    logic [mwgs_pkg::QPTR_BITS-1:0]   r_wr;
    logic [mwgs_pkg::QPTR_BITS-1:0]   r_rd;
    logic [mwgs_pkg::QPTR_BITS:0]     r_cnt;

    assign o_space = (r_cnt <= (mwgs_pkg::QPTR_BITS+1)'(mwgs_pkg::QDEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

FILE: design/mwgs_back.sv
// Back part: accumulates the weighted taps, divides by the weight total
// with rounding, saturates and holds the result. Depends on mwgs_pkg.
`timescale 1ns / 1ps
`include "masked_weighted_grid_smoother_top_macros.svh"
module mwgs_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  mwgs_pkg::t_job                       i_job,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [4*mwgs_pkg::VALUE_BITS+15:0]   o_m_tdata,
    output logic                                 o_m_tlast,
    output logic                                 o_m_tuser
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ACC  = 3'd1;
    localparam logic [2:0] B_PREP = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;
    localparam int DIV_STEPS = mwgs_pkg::SUM_BITS;
    localparam logic signed [mwgs_pkg::SUM_BITS:0] VMAX =
        (mwgs_pkg::SUM_BITS+1)'((64'd1 << (mwgs_pkg::VALUE_BITS - 1)) - 64'd1);
    localparam logic signed [mwgs_pkg::SUM_BITS:0] VMIN = -VMAX - 1;

    logic [2:0]                                  r_state;
    mwgs_pkg::t_job                              r_job;
    logic [3:0]                                  r_idx;
    logic [5:0]                                  r_step;
    logic [mwgs_pkg::WS_BITS-1:0]                r_ws;
    logic signed [mwgs_pkg::SUM_BITS-1:0]        r_sum [mwgs_pkg::NUM_LANES];
    logic [mwgs_pkg::SUM_BITS-1:0]               r_div [mwgs_pkg::NUM_LANES];
    logic [mwgs_pkg::WS_BITS-1:0]                r_rem [mwgs_pkg::NUM_LANES];
    logic                                        r_neg [mwgs_pkg::NUM_LANES];
    logic                                        r_out_valid;
    logic [4*mwgs_pkg::VALUE_BITS+15:0]          r_out_data;
    logic                                        r_out_last;
    logic                                        r_out_done;

    mwgs_pkg::t_tap                              tap;
    logic                                        load_out;
    mwgs_pkg::t_value [mwgs_pkg::NUM_LANES-1:0]  res;
    logic signed [mwgs_pkg::SUM_BITS:0]          sres;

    assign tap        = r_job.taps[r_idx];
    assign o_pop      = (r_state == B_IDLE) && i_valid;
    assign load_out   = (r_state == B_FIN) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    always_comb begin
        sres = '0;
        for (int f = 0; f < mwgs_pkg::NUM_LANES; f++) begin
            sres = r_neg[f] ? -$signed({1'b0, r_div[f]}) : $signed({1'b0, r_div[f]});
            if (r_ws == '0) begin
                res[f] = r_job.taps[mwgs_pkg::CENTER_TAP].vals[f];
            end else if (sres > VMAX) begin
                res[f] = mwgs_pkg::VALUE_BITS'(VMAX);
            end else if (sres < VMIN) begin
                res[f] = mwgs_pkg::VALUE_BITS'(VMIN);
            end else begin
                res[f] = mwgs_pkg::VALUE_BITS'(sres);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_state <= B_ACC;
                    end
                end
                B_ACC: begin
                    if (r_idx == 4'(mwgs_pkg::NUM_TAPS - 1)) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_state <= (r_ws == '0) ? B_FIN : B_DIV;
                end
                B_DIV: begin
                    if (r_step == 6'(DIV_STEPS - 1)) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [mwgs_pkg::SUM_BITS-1:0] ext;
        logic [mwgs_pkg::SUM_BITS-1:0]        mag;
        logic [mwgs_pkg::WS_BITS:0]           t;
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_idx <= '0;
                r_ws  <= '0;
                for (int f = 0; f < mwgs_pkg::NUM_LANES; f++) begin
                    r_sum[f] <= '0;
                end
            end
            B_ACC: begin
                r_idx <= r_idx + 1'b1;
                r_ws  <= r_ws + mwgs_pkg::WS_BITS'(tap.wt);
                for (int f = 0; f < mwgs_pkg::NUM_LANES; f++) begin
                    ext = mwgs_pkg::SUM_BITS'($signed(tap.vals[f]));
                    case (tap.wt)
                        mwgs_pkg::W_CORNER: r_sum[f] <= r_sum[f] + ext;
                        mwgs_pkg::W_EDGE:   r_sum[f] <= r_sum[f] + (ext <<< 1);
                        mwgs_pkg::W_CENTER: r_sum[f] <= r_sum[f] + (ext <<< 2);
                        default:            r_sum[f] <= r_sum[f];
                    endcase
                end
            end
            B_PREP: begin
                r_step <= '0;
                for (int f = 0; f < mwgs_pkg::NUM_LANES; f++) begin
                    mag = r_sum[f][mwgs_pkg::SUM_BITS-1] ? -r_sum[f] : r_sum[f];
                    r_neg[f] <= r_sum[f][mwgs_pkg::SUM_BITS-1];
                    r_div[f] <= mag + mwgs_pkg::SUM_BITS'(r_ws >> 1);
                    r_rem[f] <= '0;
                end
            end
            B_DIV: begin
                r_step <= r_step + 1'b1;
                for (int f = 0; f < mwgs_pkg::NUM_LANES; f++) begin
                    t = {r_rem[f], r_div[f][mwgs_pkg::SUM_BITS-1]};
                    if (t >= {1'b0, r_ws}) begin
                        r_rem[f] <= mwgs_pkg::WS_BITS'(t - {1'b0, r_ws});
                        r_div[f] <= {r_div[f][mwgs_pkg::SUM_BITS-2:0], 1'b1};
                    end else begin
                        r_rem[f] <= mwgs_pkg::WS_BITS'(t);
                        r_div[f] <= {r_div[f][mwgs_pkg::SUM_BITS-2:0], 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_data <= {res[3], res[2], res[1], res[0], r_job.col, r_job.row};
            r_out_last <= r_job.last;
            r_out_done <= r_job.done;
        end
    end

    `MWGS_CHECK(a_ws_bound, r_ws <= 5'd16, "weight total above sixteen")
    `MWGS_CHECK(a_idx_bound, (r_state == B_ACC) |-> (r_idx < 4'd9), "tap index out of range")
    `MWGS_CHECK(a_div_bound, (r_state == B_DIV) |-> (r_step < 6'd36), "divider ran too long")
    `MWGS_CHECK_NEXT(a_fin_loads, load_out, r_out_valid, "finished result not presented")
endmodule

FILE: design/masked_weighted_grid_smoother_top.sv
// Top level of the masked weighted grid smoother.
// Instantiates mwgs_front, mwgs_jobq and mwgs_back; depends on mwgs_pkg.
//
// Cells enter on the s-side stream in raster order, grid_height rows of
// grid_width cells followed by one padding row per frame. Smoothed cells
// leave on the m-side stream, one row and one column behind the input;
// tlast marks the final result of an input cell, tuser the frame's last cell.
// Configuration writes must go to the cfg channel only while the block is
// idle, which the block itself does not enforce; each write restarts the frame.
// The front takes a cell while idle and the queue has space (line-buffer
// read), then updates the window and issues one job, or two at a row end.
// The back part accumulates the 9 taps, runs a 36-step bit-serial divider
// for a nonzero weight total, and pops no new job until its result loads.
// A four-entry job queue lets the front run ahead of the back part.
// Reset clears counters, the queue and the output valid; line-buffer
// contents stay undefined until written. When the receiver stalls, the
// result holds in the output register and the queue fills until the input
// side is held off.
`timescale 1ns / 1ps
module masked_weighted_grid_smoother_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // scale_in, offset_in, ref_bg_in, target_bg_in
    input  logic [4*mwgs_pkg::VALUE_BITS-1:0]    s_axis_tdata,
    // cell_valid
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_row, out_col, scale_out, offset_out, ref_bg_out, target_bg_out
    output logic [4*mwgs_pkg::VALUE_BITS+15:0]   m_axis_tdata,
    // last_in_run
    output logic                                 m_axis_tlast,
    // frame_done
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwgs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [mwgs_pkg::DIM_BITS-1:0]        i_cfg_data
);
    logic           push;
    logic           q_space;
    logic           q_valid;
    logic           pop;
    mwgs_pkg::t_job push_job;
    mwgs_pkg::t_job head_job;

    mwgs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_space   (q_space),
        .o_push      (push),
        .o_job       (push_job)
    );

    mwgs_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    mwgs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );
endmodule
